@@ rtl/nls_pkg.sv @@
// ----------------------------------------------------------------------------
// nls_pkg
// Shared codes and types for the nearest light selector.
// ----------------------------------------------------------------------------
`default_nettype none
package nls_pkg;

  localparam logic [2:0] FUNC_CLR_FIXED  = 3'd0;
  localparam logic [2:0] FUNC_ADD_FIXED  = 3'd1;
  localparam logic [2:0] FUNC_CLR_MOVING = 3'd2;
  localparam logic [2:0] FUNC_ADD_MOVING = 3'd3;
  localparam logic [2:0] FUNC_QUERY      = 3'd4;

  localparam int LIGHT_W = 88;

  typedef struct packed {
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic signed [23:0] z;
    logic        [15:0] power;
  } light_t;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_MRD   = 7'b0000010,
    S_MWR   = 7'b0000100,
    S_SCAN  = 7'b0001000,
    S_FRD   = 7'b0010000,
    S_FWR   = 7'b0100000,
    S_EMPTY = 7'b1000000
  } state_t;

endpackage
`default_nettype wire

@@ rtl/nls_if.sv @@
// ----------------------------------------------------------------------------
// nls_if
// Word channels of the selector: request words in, light words out.
// ----------------------------------------------------------------------------
`default_nettype none
interface nls_in_if;
  logic               valid;
  logic               ready;
  logic        [2:0]  func;
  logic signed [23:0] pos_x;
  logic signed [23:0] pos_y;
  logic signed [23:0] pos_z;
  logic        [15:0] power;
  modport source (output valid, func, pos_x, pos_y, pos_z, power, input ready);
  modport sink   (input valid, func, pos_x, pos_y, pos_z, power, output ready);
endinterface

interface nls_out_if;
  logic               valid;
  logic               ready;
  logic               valid_res;
  logic               last;
  logic               is_transient;
  logic        [5:0]  slot;
  logic        [49:0] dist_sq;
  logic signed [23:0] light_x;
  logic signed [23:0] light_y;
  logic signed [23:0] light_z;
  logic        [15:0] light_power;
  logic               overflow;
  modport source (output valid, valid_res, last, is_transient, slot, dist_sq,
                  light_x, light_y, light_z, light_power, overflow, input ready);
  modport sink   (input valid, valid_res, last, is_transient, slot, dist_sq,
                  light_x, light_y, light_z, light_power, overflow, output ready);
  modport monitor (input valid, ready, valid_res, last, is_transient, slot, dist_sq,
                   light_x, light_y, light_z, light_power, overflow);
endinterface
`default_nettype wire

@@ rtl/nls_ram.sv @@
// ----------------------------------------------------------------------------
// nls_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module nls_ram #(
  parameter int W = 8,
  parameter int D = 16,
  localparam int AW = (D > 1) ? $clog2(D) : 1
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [W-1:0]  wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [W-1:0]  rdata
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

@@ rtl/nls_dist.sv @@
// ----------------------------------------------------------------------------
// nls_dist
// Three-stage squared distance pipeline: differences, squares, sum.
// ----------------------------------------------------------------------------
`default_nettype none
module nls_dist #(
  parameter int AW = 6
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire logic [AW-1:0]      in_slot,
  input  wire nls_pkg::light_t    lt,
  input  wire logic signed [23:0] qx,
  input  wire logic signed [23:0] qy,
  input  wire logic signed [23:0] qz,
  output logic                    out_valid,
  output logic [AW-1:0]           out_slot,
  output logic [49:0]             out_dist,
  output logic                    busy
);
  import nls_pkg::*;

  logic               v1, v2;
  logic [AW-1:0]      slot1, slot2;
  logic signed [24:0] dx, dy, dz;
  logic signed [49:0] sx, sy, sz;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1        <= in_valid;
      v2        <= v1;
      out_valid <= v2;
    end
    slot1    <= in_slot;
    dx       <= {lt.x[23], lt.x} - {qx[23], qx};
    dy       <= {lt.y[23], lt.y} - {qy[23], qy};
    dz       <= {lt.z[23], lt.z} - {qz[23], qz};
    slot2    <= slot1;
    sx       <= 50'(dx) * 50'(dx);
    sy       <= 50'(dy) * 50'(dy);
    sz       <= 50'(dz) * 50'(dz);
    out_slot <= slot2;
    out_dist <= 50'(sx) + 50'(sy) + 50'(sz);
  end

  assign busy = v1 | v2 | out_valid;
endmodule
`default_nettype wire

@@ rtl/nls_rank.sv @@
// ----------------------------------------------------------------------------
// nls_rank
// Sorted insertion list of the nearest fixed lights seen in a scan.
// ----------------------------------------------------------------------------
`default_nettype none
module nls_rank #(
  parameter int MAX_OUT = 16,
  parameter int AW      = 6,
  parameter int CW      = 7,
  localparam int OAW    = (MAX_OUT > 1) ? $clog2(MAX_OUT) : 1
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           clr,
  input  wire logic           in_valid,
  input  wire logic [AW-1:0]  in_slot,
  input  wire logic [49:0]    in_dist,
  input  wire logic [CW-1:0]  take,
  input  wire logic [OAW-1:0] rd_idx,
  output logic      [AW-1:0]  rd_slot,
  output logic      [49:0]    rd_dist
);
  import nls_pkg::*;

  logic [49:0]   dl [MAX_OUT];
  logic [AW-1:0] sl [MAX_OUT];
  logic [CW-1:0] len;
  logic [MAX_OUT-1:0] le;
  logic [CW-1:0] pos;

  always_comb begin
    for (int j = 0; j < MAX_OUT; j++) begin
      le[j] = (CW'(j) < len) && (dl[j] <= in_dist);
    end
    pos = CW'($countones(le));
  end

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      len <= '0;
    end else if (in_valid && pos < take) begin
      if (len < take) begin
        len <= len + CW'(1);
      end
    end
    if (!clr && in_valid && pos < take) begin
      for (int j = MAX_OUT - 1; j >= 0; j--) begin
        if (CW'(j) == pos) begin
          dl[j] <= in_dist;
          sl[j] <= in_slot;
        end else if (CW'(j) > pos && j > 0) begin
          dl[j] <= dl[j-1];
          sl[j] <= sl[j-1];
        end
      end
    end
  end

  assign rd_slot = sl[rd_idx];
  assign rd_dist = dl[rd_idx];
endmodule
`default_nettype wire

@@ rtl/nearest_light_selector_unit.sv @@
// ----------------------------------------------------------------------------
// nearest_light_selector_unit
// Fixed and moving light stores with a nearest-light query.
// ----------------------------------------------------------------------------
// Request words arrive on in_ch: clear or add to the fixed or moving store,
// or a query at a point. Adds and clears return nothing.
// A query returns on out_ch first the moving lights in load order, then
// the nearest fixed lights by rising squared distance, in all at most
// max_out (and MAX_OUT) words; the final word carries last. With nothing to
// return one word with valid_res low and last high is sent.
// Query steps: each moving light is read from the moving store and sent; the
// fixed lights are scanned through the fixed store read port and distance
// pipeline; then each fixed light sent is read back from the fixed store.
// One query at a time.
// A stalled receiver holds the output register and the query halts there;
// adds and clears are still taken while a final word waits.
// Reset empties both stores, clears overflow and sets max_out to 8; store
// contents are left as they are. max_out is at APB address 0.
// ----------------------------------------------------------------------------
`default_nettype none
module nearest_light_selector_unit #(
  parameter int MAX_FIXED_LIGHTS  = 64,
  parameter int MAX_MOVING_LIGHTS = 8,
  parameter int MAX_OUT           = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  nls_in_if.sink           in_ch,
  nls_out_if.source        out_ch
);
  import nls_pkg::*;

  localparam int FAW = (MAX_FIXED_LIGHTS > 1) ? $clog2(MAX_FIXED_LIGHTS) : 1;
  localparam int MAW = (MAX_MOVING_LIGHTS > 1) ? $clog2(MAX_MOVING_LIGHTS) : 1;
  localparam int OAW = (MAX_OUT > 1) ? $clog2(MAX_OUT) : 1;
  localparam int FCW = $clog2(MAX_FIXED_LIGHTS + 1);
  localparam int MCW = $clog2(MAX_MOVING_LIGHTS + 1);
  localparam int CW0 = (FCW > MCW) ? FCW : MCW;
  localparam int CW1 = (CW0 > $clog2(MAX_OUT + 1)) ? CW0 : $clog2(MAX_OUT + 1);
  localparam int CW  = (CW1 > 7) ? CW1 : 7;

  state_t state;

  logic [4:0]     max_out;
  logic [FCW-1:0] fcount;
  logic [MCW-1:0] mcount;
  logic           dropped;
  logic signed [23:0] qx, qy, qz;
  logic [CW-1:0]  n_mv, take, idx, scan_idx;
  logic           rd_valid;
  logic [FAW-1:0] rd_slot;

  logic [CW-1:0]  limit, n_c, rest, take_c;

  logic           f_we, f_re, m_we, m_re;
  logic [FAW-1:0] f_raddr;
  light_t         f_rdata, m_rdata, wr_light;

  logic           d_valid, d_busy;
  logic [FAW-1:0] d_slot;
  logic [49:0]    d_dist;
  logic           rank_clr;
  logic [FAW-1:0] r_slot;
  logic [49:0]    r_dist;

  logic           in_fire, out_free, load;
  logic           ld_vres, ld_last, ld_tr;
  logic [5:0]     ld_slot;
  logic [49:0]    ld_dist;
  light_t         ld_light;

  // configuration port
  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {27'd0, max_out};

  always_ff @(posedge clk) begin
    if (rst) begin
      max_out <= 5'd8;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      max_out <= pwdata[4:0];
    end
  end

  assign in_ch.ready = (state == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_ch.valid || out_ch.ready;

  assign wr_light = '{x: in_ch.pos_x, y: in_ch.pos_y, z: in_ch.pos_z, power: in_ch.power};

  always_comb begin
    limit  = (CW'(max_out) > CW'(MAX_OUT)) ? CW'(MAX_OUT) : CW'(max_out);
    n_c    = (CW'(mcount) < limit) ? CW'(mcount) : limit;
    rest   = limit - n_c;
    take_c = (rest > CW'(fcount)) ? CW'(fcount) : rest;
  end

  assign f_we = in_fire && in_ch.func == FUNC_ADD_FIXED && in_ch.power != 16'd0 &&
                fcount != FCW'(MAX_FIXED_LIGHTS);
  assign m_we = in_fire && in_ch.func == FUNC_ADD_MOVING && in_ch.power != 16'd0 &&
                mcount != MCW'(MAX_MOVING_LIGHTS);
  assign m_re = (state == S_MRD);
  assign f_re = (state == S_FRD) || (state == S_SCAN && scan_idx < CW'(fcount));
  assign f_raddr = (state == S_SCAN) ? scan_idx[FAW-1:0] : r_slot;
  assign rank_clr = in_fire && in_ch.func == FUNC_QUERY;

  nls_ram #(.W(LIGHT_W), .D(MAX_FIXED_LIGHTS)) u_fixed_ram (
    .clk   (clk),
    .we    (f_we),
    .waddr (fcount[FAW-1:0]),
    .wdata (wr_light),
    .re    (f_re),
    .raddr (f_raddr),
    .rdata (f_rdata)
  );

  nls_ram #(.W(LIGHT_W), .D(MAX_MOVING_LIGHTS)) u_moving_ram (
    .clk   (clk),
    .we    (m_we),
    .waddr (mcount[MAW-1:0]),
    .wdata (wr_light),
    .re    (m_re),
    .raddr (idx[MAW-1:0]),
    .rdata (m_rdata)
  );

  nls_dist #(.AW(FAW)) u_dist (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (rd_valid),
    .in_slot   (rd_slot),
    .lt        (f_rdata),
    .qx        (qx),
    .qy        (qy),
    .qz        (qz),
    .out_valid (d_valid),
    .out_slot  (d_slot),
    .out_dist  (d_dist),
    .busy      (d_busy)
  );

  nls_rank #(.MAX_OUT(MAX_OUT), .AW(FAW), .CW(CW)) u_rank (
    .clk      (clk),
    .rst      (rst),
    .clr      (rank_clr),
    .in_valid (d_valid),
    .in_slot  (d_slot),
    .in_dist  (d_dist),
    .take     (take),
    .rd_idx   (idx[OAW-1:0]),
    .rd_slot  (r_slot),
    .rd_dist  (r_dist)
  );

  // output word selection
  always_comb begin
    load     = 1'b0;
    ld_vres  = 1'b1;
    ld_last  = 1'b0;
    ld_tr    = 1'b0;
    ld_slot  = 6'd0;
    ld_dist  = 50'd0;
    ld_light = '0;
    case (state)
      S_MWR: begin
        load     = out_free;
        ld_tr    = 1'b1;
        ld_slot  = idx[5:0];
        ld_light = m_rdata;
        ld_last  = (idx == n_mv - CW'(1)) && (take == '0);
      end
      S_FWR: begin
        load     = out_free;
        ld_slot  = 6'(r_slot);
        ld_dist  = r_dist;
        ld_light = f_rdata;
        ld_last  = (idx == take - CW'(1));
      end
      S_EMPTY: begin
        load    = out_free;
        ld_vres = 1'b0;
        ld_last = 1'b1;
      end
      default: begin
        load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (load) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
    if (load) begin
      out_ch.valid_res    <= ld_vres;
      out_ch.last         <= ld_last;
      out_ch.is_transient <= ld_tr;
      out_ch.slot         <= ld_slot;
      out_ch.dist_sq      <= ld_dist;
      out_ch.light_x      <= ld_light.x;
      out_ch.light_y      <= ld_light.y;
      out_ch.light_z      <= ld_light.z;
      out_ch.light_power  <= ld_light.power;
      out_ch.overflow     <= dropped;
    end
  end

  // control
  always_ff @(posedge clk) begin
    rd_slot <= scan_idx[FAW-1:0];
    if (rst) begin
      state    <= S_IDLE;
      fcount   <= '0;
      mcount   <= '0;
      dropped  <= 1'b0;
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= (state == S_SCAN) && (scan_idx < CW'(fcount));
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            case (in_ch.func)
              FUNC_CLR_FIXED:  fcount <= '0;
              FUNC_CLR_MOVING: mcount <= '0;
              FUNC_ADD_FIXED: begin
                if (in_ch.power != 16'd0) begin
                  if (f_we) fcount <= fcount + FCW'(1);
                  else      dropped <= 1'b1;
                end
              end
              FUNC_ADD_MOVING: begin
                if (in_ch.power != 16'd0) begin
                  if (m_we) mcount <= mcount + MCW'(1);
                  else      dropped <= 1'b1;
                end
              end
              FUNC_QUERY: begin
                qx       <= in_ch.pos_x;
                qy       <= in_ch.pos_y;
                qz       <= in_ch.pos_z;
                n_mv     <= n_c;
                take     <= take_c;
                idx      <= '0;
                scan_idx <= '0;
                if (n_c != '0)         state <= S_MRD;
                else if (take_c != '0) state <= S_SCAN;
                else                   state <= S_EMPTY;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_MRD: state <= S_MWR;
        S_MWR: begin
          if (load) begin
            if (idx == n_mv - CW'(1)) begin
              idx   <= '0;
              state <= (take != '0) ? S_SCAN : S_IDLE;
            end else begin
              idx   <= idx + CW'(1);
              state <= S_MRD;
            end
          end
        end
        S_SCAN: begin
          if (scan_idx < CW'(fcount)) begin
            scan_idx <= scan_idx + CW'(1);
          end else if (!rd_valid && !d_busy) begin
            idx   <= '0;
            state <= S_FRD;
          end
        end
        S_FRD: state <= S_FWR;
        S_FWR: begin
          if (load) begin
            if (idx == take - CW'(1)) begin
              state <= S_IDLE;
            end else begin
              idx   <= idx + CW'(1);
              state <= S_FRD;
            end
          end
        end
        S_EMPTY: begin
          if (load) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

@@ rtl/nls_checker.sv @@
// ----------------------------------------------------------------------------
// nls_checker
// Port-level checks on the selector's output words, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module nls_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        valid,
  input wire logic        ready,
  input wire logic        valid_res,
  input wire logic        last,
  input wire logic        is_transient,
  input wire logic [49:0] dist_sq,
  input wire logic [15:0] light_power
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    valid && !ready |=> valid)
    else $error("output word dropped while stalled");

  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    valid && !valid_res |-> last)
    else $error("empty word without last");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    valid && !valid_res |-> light_power == 16'd0 && dist_sq == 50'd0)
    else $error("empty word carries data");

  a_moving_dist: assert property (@(posedge clk) disable iff (rst)
    valid && is_transient |-> dist_sq == 50'd0 && light_power != 16'd0)
    else $error("moving light word malformed");
endmodule

bind nearest_light_selector_unit nls_checker u_nls_checker (
  .clk          (clk),
  .rst          (rst),
  .valid        (out_ch.valid),
  .ready        (out_ch.ready),
  .valid_res    (out_ch.valid_res),
  .last         (out_ch.last),
  .is_transient (out_ch.is_transient),
  .dist_sq      (out_ch.dist_sq),
  .light_power  (out_ch.light_power)
);
`default_nettype wire
